// ===== hdl/vmrx_pkg.sv =====
// Package with the opcodes, width masks and the queue entry type of the execute unit.
`timescale 1ns / 1ps
package vmrx_pkg;

  localparam logic [4:0] OP_MOVE    = 5'd0;
  localparam logic [4:0] OP_ADD     = 5'd1;
  localparam logic [4:0] OP_SUB     = 5'd2;
  localparam logic [4:0] OP_LSL     = 5'd3;
  localparam logic [4:0] OP_LSR     = 5'd4;
  localparam logic [4:0] OP_NOT     = 5'd5;
  localparam logic [4:0] OP_XOR     = 5'd6;
  localparam logic [4:0] OP_AND     = 5'd7;
  localparam logic [4:0] OP_OR      = 5'd8;
  localparam logic [4:0] OP_INC     = 5'd9;
  localparam logic [4:0] OP_DEC     = 5'd10;
  localparam logic [4:0] OP_SET     = 5'd11;
  localparam logic [4:0] OP_JMP     = 5'd12;
  localparam logic [4:0] OP_JEQ     = 5'd13;
  localparam logic [4:0] OP_JNE     = 5'd14;
  localparam logic [4:0] OP_BRA     = 5'd15;
  localparam logic [4:0] OP_BEQ     = 5'd16;
  localparam logic [4:0] OP_BNE     = 5'd17;
  localparam logic [4:0] OP_EXIT    = 5'd18;
  localparam logic [4:0] OP_ADDR_OF = 5'd19;

  localparam logic [1:0] SIZE_BYTE  = 2'd0;
  localparam logic [1:0] SIZE_HALF  = 2'd1;
  localparam logic [1:0] SIZE_WORD  = 2'd2;
  localparam logic [1:0] SIZE_DWORD = 2'd3;

  localparam logic [63:0] BRANCH_BIAS = 64'd8;
  localparam logic [31:0] BAD_OP_CODE = 32'hffff_ffff;

  // Decoded instruction as it waits between front and back.
  typedef struct packed {
    logic [4:0]  op;
    logic [63:0] mask;
    logic [15:0] src_idx;
    logic [15:0] dst_idx;
    logic [63:0] immediate;
    logic [63:0] next_addr;
  } item_t;

  // Result transaction.
  typedef struct packed {
    logic [31:0] exit_code;
    logic        exit_flag;
    logic [63:0] next_pc;
    logic        branch_taken;
    logic [63:0] write_value;
    logic [11:0] write_reg;
    logic        write_enable;
  } result_t;

  function automatic logic [63:0] width_mask(input logic [1:0] size_code);
    logic [63:0] m;
    unique case (size_code)
      SIZE_BYTE: m = 64'h0000_0000_0000_00ff;
      SIZE_HALF: m = 64'h0000_0000_0000_ffff;
      SIZE_WORD: m = 64'h0000_0000_ffff_ffff;
      default:   m = 64'hffff_ffff_ffff_ffff;
    endcase
    return m;
  endfunction

endpackage

// ===== hdl/vmrx_front.sv =====
// Front stage: unpacks an instruction, builds its width mask and wraps register indexes.
`timescale 1ns / 1ps
module vmrx_front import vmrx_pkg::*; #(
  parameter int NUM_REGS = 4096
) (
  input  logic [159:0] tdata_i,
  output item_t        item_o
);

  localparam int NW = 20;
  localparam logic [NW-1:0] N = NW'(NUM_REGS);

  // Restoring remainder; the index stays below 256 times the file depth.
  function automatic logic [15:0] wrap_index(input logic [11:0] r);
    logic [NW-1:0] v;
    v = NW'(r);
    if (NUM_REGS < 4096) begin
      for (int k = 7; k >= 0; k--) begin
        if (v >= (N << k)) v = v - (N << k);
      end
    end
    return v[15:0];
  endfunction

  always_comb begin
    item_o.op        = tdata_i[4:0];
    item_o.mask      = width_mask(tdata_i[6:5]);
    item_o.src_idx   = wrap_index(tdata_i[18:7]);
    item_o.dst_idx   = wrap_index(tdata_i[30:19]);
    item_o.immediate = tdata_i[94:31];
    item_o.next_addr = tdata_i[158:95];
  end

endmodule

// ===== hdl/vmrx_fifo.sv =====
// Two-entry queue between front and back.
`timescale 1ns / 1ps
module vmrx_fifo import vmrx_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t push_item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output item_t pop_item_o
);

  item_t      mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o     = cnt_q == 2'd2;
  assign empty_o    = cnt_q == 2'd0;
  assign pop_item_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      if (push_i && !pop_i) cnt_q <= cnt_q + 2'd1;
      else if (!push_i && pop_i) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_item_i;
  end

endmodule

// ===== hdl/vmrx_back.sv =====
// Back stage: register file read, execute, write-back and the output register.
`timescale 1ns / 1ps
module vmrx_back import vmrx_pkg::*; #(
  parameter int NUM_REGS = 4096
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  item_t         item_i,
  output logic          pop_o,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [175:0]  m_axis_tdata
);

  localparam int IDX_W = $clog2(NUM_REGS);

  logic [63:0] regs_q [NUM_REGS];
  logic [63:0] src_val_q, dst_val_q;
  item_t       cur_q;
  logic        exec_q;
  logic        out_valid_q;
  result_t     out_q;
  logic        out_free, finish;
  logic [63:0] m, a, d, low, full, sum3;
  logic        narrow_wr;
  result_t     res;

  assign out_free = !out_valid_q || m_axis_tready;
  assign finish   = exec_q && out_free;
  // A read is issued only in a cycle without write-back, so no forwarding is needed.
  assign pop_o    = !exec_q && !empty_i;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      src_val_q <= regs_q[item_i.src_idx[IDX_W-1:0]];
      dst_val_q <= regs_q[item_i.dst_idx[IDX_W-1:0]];
      cur_q     <= item_i;
    end
    if (finish && res.write_enable) regs_q[cur_q.dst_idx[IDX_W-1:0]] <= res.write_value;
    if (finish) out_q <= res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exec_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) exec_q <= 1'b1;
      else if (finish) exec_q <= 1'b0;
      if (finish) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  always_comb begin
    m         = cur_q.mask;
    a         = src_val_q & m;
    d         = dst_val_q & m;
    sum3      = cur_q.next_addr + cur_q.immediate - BRANCH_BIAS;
    low       = '0;
    narrow_wr = 1'b0;
    full      = '0;
    res       = '0;
    res.next_pc = cur_q.next_addr;
    unique case (cur_q.op)
      OP_MOVE: begin low = a; narrow_wr = 1'b1; end
      OP_ADD:  begin low = d + a; narrow_wr = 1'b1; end
      OP_SUB:  begin low = d - a; narrow_wr = 1'b1; end
      OP_LSL: begin
        low = (cur_q.immediate >= 64'd64) ? '0 : d << cur_q.immediate[5:0];
        narrow_wr = 1'b1;
      end
      OP_LSR: begin
        low = (cur_q.immediate >= 64'd64) ? '0 : d >> cur_q.immediate[5:0];
        narrow_wr = 1'b1;
      end
      OP_NOT:  begin low = ~d; narrow_wr = 1'b1; end
      OP_XOR:  begin low = d ^ a; narrow_wr = 1'b1; end
      OP_AND:  begin low = d & a; narrow_wr = 1'b1; end
      OP_OR:   begin low = d | a; narrow_wr = 1'b1; end
      OP_INC:  begin low = d + (cur_q.immediate & m); narrow_wr = 1'b1; end
      OP_DEC:  begin low = d - (cur_q.immediate & m); narrow_wr = 1'b1; end
      OP_SET:  begin low = cur_q.immediate; narrow_wr = 1'b1; end
      OP_JMP: begin res.branch_taken = 1'b1; res.next_pc = dst_val_q; end
      OP_JEQ: begin
        if (a == '0) begin res.branch_taken = 1'b1; res.next_pc = dst_val_q; end
      end
      OP_JNE: begin
        if (a != '0) begin res.branch_taken = 1'b1; res.next_pc = dst_val_q; end
      end
      OP_BRA: begin res.branch_taken = 1'b1; res.next_pc = sum3; end
      OP_BEQ: begin
        if (d == '0) begin
          res.branch_taken = 1'b1;
          res.next_pc = cur_q.next_addr + cur_q.immediate;
        end
      end
      OP_BNE: begin
        if (d != '0) begin
          res.branch_taken = 1'b1;
          res.next_pc = cur_q.next_addr + cur_q.immediate;
        end
      end
      OP_EXIT: begin res.exit_flag = 1'b1; res.exit_code = cur_q.immediate[31:0]; end
      OP_ADDR_OF: begin full = sum3; res.write_enable = 1'b1; end
      default: begin res.exit_flag = 1'b1; res.exit_code = BAD_OP_CODE; end
    endcase
    if (narrow_wr) begin
      full = (dst_val_q & ~m) | (low & m);
      res.write_enable = 1'b1;
    end
    if (res.write_enable) begin
      res.write_reg   = 12'(cur_q.dst_idx);
      res.write_value = full;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_q};

endmodule

// ===== hdl/vm_register_execute_unit.sv =====
// Top level of the register execute unit.
`timescale 1ns / 1ps
// Executes one decoded instruction per transaction against a file of NUM_REGS 64-bit
// registers and returns one result transaction with the write-back, the next pc and the
// exit status. In the back stage an instruction first reads both operands from the
// synchronous register file and is then executed and written back; the next instruction
// is read only after that write-back. A two-entry queue and an output register keep
// input acceptance going while a result waits, until the queue is full. Register contents
// are undefined until first written. Indexes of NUM_REGS or more wrap modulo NUM_REGS.
module vm_register_execute_unit import vmrx_pkg::*; #(
  parameter int NUM_REGS = 4096
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // op, size_code, src_reg, dst_reg, immediate, next_addr, from bit 0 up; one zero pad bit
  input  logic [159:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // write_enable, write_reg, write_value, branch_taken, next_pc, exit_flag, exit_code,
  // from bit 0 up; one zero pad bit
  output logic [175:0] m_axis_tdata
);

  item_t front_item, queue_item;
  logic  full, empty, pop;

  vmrx_front #(.NUM_REGS(NUM_REGS)) u_front (
    .tdata_i (s_axis_tdata),
    .item_o  (front_item)
  );

  assign s_axis_tready = !full;

  vmrx_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s_axis_tvalid && !full),
    .push_item_i (front_item),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .pop_item_o  (queue_item)
  );

  vmrx_back #(.NUM_REGS(NUM_REGS)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .item_i        (queue_item),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// ===== dv/vm_register_execute_unit_checker.sv =====
// Checker that predicts and compares the result transactions of the execute unit.
`timescale 1ns / 1ps
module vm_register_execute_unit_checker import vmrx_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [159:0] s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [175:0] m_axis_tdata,
  output int           fail_count_o,
  output int           pending_o
);

  logic [63:0] regs_model [4096];
  result_t     expected_results [$];
  int          mismatches;

  function automatic logic [63:0] size_mask(input logic [1:0] sz);
    case (sz)
      SIZE_BYTE: return 64'hff;
      SIZE_HALF: return 64'hffff;
      SIZE_WORD: return 64'hffff_ffff;
      default:   return '1;
    endcase
  endfunction

  // Executes one instruction on the model register file and returns its result.
  function automatic result_t execute_instr(input logic [159:0] d);
    logic [4:0]  op;
    logic [63:0] m, imm, nxt, a, dv, low, full;
    logic [11:0] src, dst;
    logic        narrow, wr;
    result_t     r;
    op = d[4:0];
    m = size_mask(d[6:5]);
    src = d[18:7];
    dst = d[30:19];
    imm = d[94:31];
    nxt = d[158:95];
    a = regs_model[src] & m;
    dv = regs_model[dst] & m;
    low = '0;
    full = '0;
    narrow = 1'b0;
    wr = 1'b0;
    r = '0;
    r.next_pc = nxt;
    case (op)
      OP_MOVE:   begin low = a; narrow = 1'b1; end
      OP_ADD:    begin low = dv + a; narrow = 1'b1; end
      OP_SUB:    begin low = dv - a; narrow = 1'b1; end
      OP_LSL:    begin low = (imm >= 64) ? '0 : dv << imm; narrow = 1'b1; end
      OP_LSR:    begin low = (imm >= 64) ? '0 : dv >> imm; narrow = 1'b1; end
      OP_NOT:    begin low = ~dv; narrow = 1'b1; end
      OP_XOR:    begin low = dv ^ a; narrow = 1'b1; end
      OP_AND:    begin low = dv & a; narrow = 1'b1; end
      OP_OR:     begin low = dv | a; narrow = 1'b1; end
      OP_INC:    begin low = dv + (imm & m); narrow = 1'b1; end
      OP_DEC:    begin low = dv - (imm & m); narrow = 1'b1; end
      OP_SET:    begin low = imm; narrow = 1'b1; end
      OP_JMP:    begin r.branch_taken = 1'b1; r.next_pc = regs_model[dst]; end
      OP_JEQ: if (a == 0) begin
        r.branch_taken = 1'b1;
        r.next_pc = regs_model[dst];
      end
      OP_JNE: if (a != 0) begin
        r.branch_taken = 1'b1;
        r.next_pc = regs_model[dst];
      end
      OP_BRA:    begin r.branch_taken = 1'b1; r.next_pc = nxt + imm - 64'd8; end
      OP_BEQ: if (dv == 0) begin
        r.branch_taken = 1'b1;
        r.next_pc = nxt + imm;
      end
      OP_BNE: if (dv != 0) begin
        r.branch_taken = 1'b1;
        r.next_pc = nxt + imm;
      end
      OP_EXIT:   begin r.exit_flag = 1'b1; r.exit_code = imm[31:0]; end
      OP_ADDR_OF: begin full = nxt + imm - 64'd8; wr = 1'b1; end
      default:   begin r.exit_flag = 1'b1; r.exit_code = 32'hffff_ffff; end
    endcase
    if (narrow) begin
      full = (regs_model[dst] & ~m) | (low & m);
      wr = 1'b1;
    end
    if (wr) begin
      regs_model[dst] = full;
      r.write_enable = 1'b1;
      r.write_reg = dst;
      r.write_value = full;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got, exp_r;
    if (!rst_ni) begin
      mismatches <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        expected_results.push_back(execute_instr(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[174:143], m_axis_tdata[142], m_axis_tdata[141:78],
               m_axis_tdata[77], m_axis_tdata[76:13], m_axis_tdata[12:1], m_axis_tdata[0]};
        if (expected_results.size() == 0) begin
          if (mismatches < 10) $display("unexpected result transaction %h", got);
          mismatches <= mismatches + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (got !== exp_r) begin
            if (mismatches < 10)
              $display("mismatch: we %b/%b reg %h/%h val %h/%h br %b/%b pc %h/%h ex %b/%b code %h/%h",
                       exp_r.write_enable, got.write_enable, exp_r.write_reg, got.write_reg,
                       exp_r.write_value, got.write_value, exp_r.branch_taken,
                       got.branch_taken, exp_r.next_pc, got.next_pc, exp_r.exit_flag,
                       got.exit_flag, exp_r.exit_code, got.exit_code);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end

  assign fail_count_o = mismatches + expected_results.size();
  assign pending_o = expected_results.size();

endmodule

// ===== dv/vm_register_execute_unit_test.sv =====
// Top of the execute unit testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module vm_register_execute_unit_test;
  import vmrx_pkg::*;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [159:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [175:0] m_axis_tdata;
  int           fail_count, pending;
  int           send_idle_pct, recv_idle_pct;
  bit           recv_hold = 1'b0;
  bit           hold_start = 1'b0;
  int           cycles = 0;
  // The working set is 64 registers whose index repeats a 6-bit slot number in both
  // halves, so every index bit toggles; all are set before any read.
  bit           written [64];

  always #5 clk_i = ~clk_i;

  vm_register_execute_unit i_dut (.*);

  vm_register_execute_unit_checker i_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("vm_register_execute_unit_test NOT OK");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic logic [63:0] rand64();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return 64'($urandom_range(70));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send(input logic [4:0] op, input logic [1:0] sz, input logic [11:0] src,
                      input logic [11:0] dst, input logic [63:0] imm,
                      input logic [63:0] nxt);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, nxt, imm, dst, src, sz, op};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Random instruction on written registers; destinations of writes become readable.
  task automatic send_random();
    logic [4:0] op;
    logic [5:0] ks, kd;
    logic [1:0] sz;
    op = ($urandom_range(30) == 0) ? 5'($urandom_range(20, 31)) : 5'($urandom_range(19));
    sz = 2'($urandom_range(3));
    ks = 6'($urandom_range(63));
    kd = 6'($urandom_range(63));
    while (!written[ks]) ks = 6'($urandom_range(63));
    // A narrow set keeps the upper bits, so only a full set or address-of may
    // target a register that was never written.
    if (!((op == OP_SET && sz == SIZE_DWORD) || op == OP_ADDR_OF))
      while (!written[kd]) kd = 6'($urandom_range(63));
    if (op == OP_SET || op == OP_ADDR_OF) written[kd] = 1'b1;
    send(op, sz, {ks, ks}, {kd, kd}, rand64(), rand64());
  endtask

  initial begin
    logic [4:0] op;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: extreme values, every opcode, each width, shift limits and a bad opcode.
    send(OP_SET, SIZE_DWORD, 12'd0, 12'd1, '1, '1);
    send(OP_SET, SIZE_DWORD, 12'd0, 12'd2, '0, '0);
    send(OP_SET, SIZE_BYTE, 12'd0, 12'd1, 64'h5a, 64'h10);
    for (int i = 0; i < 20; i++) begin
      op = 5'(i);
      send(op, 2'(i % 4), 12'd1 + 12'(i % 2), 12'd2 - 12'(i % 2), 64'(i * 7), 64'h100);
    end
    send(OP_LSL, SIZE_DWORD, 12'd1, 12'd1, 64'd63, 64'h8);
    send(OP_LSR, SIZE_DWORD, 12'd1, 12'd1, 64'd64, 64'h8);
    send(5'd31, SIZE_DWORD, 12'd1, 12'd1, '1, '1);
    for (int k = 0; k < 64; k++) begin
      send(OP_SET, SIZE_DWORD, 12'd0, {6'(k), 6'(k)}, rand64(), 64'd0);
      written[k] = 1'b1;
    end
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 66 : 0;
      recv_idle_pct = (phase == 0) ? 66 : (phase == 1) ? 29 : 0;
      for (int n = 0; n < 480; n++) begin
        if (phase == 2 && n == 100) hold_start = 1'b1;
        send_random();
      end
      // The sender pauses here until every expected result has come.
      s_axis_tvalid <= 1'b0;
      while (pending != 0) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0)
      $display("vm_register_execute_unit_test OK");
    else
      $display("vm_register_execute_unit_test NOT OK");
    $finish;
  end

  // Long receiver hold-off counted in cycles while the sender keeps offering.
  initial begin
    wait (hold_start);
    recv_hold = 1'b1;
    repeat (300) @(posedge clk_i);
    recv_hold = 1'b0;
  end

endmodule
